// ===== hdl/wfha_pkg.sv =====
// ----------------------------------------------------------------------------
// wfha_pkg
// shared codes and field widths for the worst-fit hole allocator
// ----------------------------------------------------------------------------
`default_nettype none

package wfha_pkg;

  // command codes carried in the input tuser
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // fixed field widths and the hole_count reset value
  localparam int unsigned HoleIdxW  = 4;
  localparam int unsigned AmountW   = 16;
  localparam int unsigned CountW    = 5;
  localparam int unsigned CountRst  = 16;
  localparam int unsigned TdataW    = 24;

  // one result item before it reaches the output register
  typedef struct packed {
    logic                granted;
    logic [HoleIdxW-1:0] chosen_hole;
    logic [AmountW-1:0]  remaining;
  } result_t;

endpackage : wfha_pkg

`default_nettype wire

// ===== hdl/worst_fit_hole_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// worst_fit_hole_allocator_unit
// worst-fit allocator over a table of free holes kept in a synchronous ram
// ----------------------------------------------------------------------------
//
//  channel   | direction | signals                           | content
//  ----------+-----------+-----------------------------------+-------------------------
//  s_axis    | in        | tvalid tready tdata[23:0] tuser   | load or request item
//  m_axis    | out       | tvalid tready tdata[23:0] tuser   | grant, hole, remaining
//  cfg       | in        | cfg_we_i cfg_wdata_i[4:0]         | hole_count register
//
//  - a load goes from ST_IDLE to ST_OUT and back to ST_IDLE for the next accept
//  - a request runs ST_SCAN, ST_UPDATE and ST_OUT (hole_count saturated at the table
//    depth): one sram read per hole in the search, the registered read data, the
//    close of the scan, a write-back, the result move into the output register, the accept
//  - the scan over the hole ram, one read per hole, sets the request rate
//  - reset clears the full marks and the control state; hole sizes are
//    undefined until loaded, no clearing pass is run
//  - a result waits in the output register while m_axis stalls; the next
//    transaction is still accepted, and only a second result blocks
//
`default_nettype none

module worst_fit_hole_allocator_unit
  import wfha_pkg::*;
#(
  parameter int unsigned MAX_HOLES = 16,
  parameter int unsigned SIZE_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [CountW-1:0] cfg_wdata_i,       // hole_count
  // input stream
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [TdataW-1:0] s_axis_tdata_i,    // [3:0] hole_index, [19:4] amount
  input  wire logic              s_axis_tuser_i,    // cmd
  // result stream
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  output logic [TdataW-1:0]      m_axis_tdata_o,    // [3:0] chosen_hole, [19:4] remaining
  output logic                   m_axis_tuser_o     // granted
);

  // derived widths
  localparam int unsigned IdxW  = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_HOLES + 1);
  localparam int unsigned LimW  = (CntW > CountW) ? CntW : CountW;
  localparam int unsigned CmpW  = (SIZE_BITS > AmountW) ? SIZE_BITS : AmountW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_OUT
  } state_e;

  state_e                 state_q;
  logic [CountW-1:0]      hole_count_q;
  logic [MAX_HOLES-1:0]   full_q;

  // request context
  logic [AmountW-1:0]     amt_q;
  logic [LimW-1:0]        limit_q;
  logic [LimW-1:0]        ptr_q;
  logic                   rd_vld_q;
  logic                   rd_full_q;
  logic [IdxW-1:0]        rd_idx_q;
  logic                   found_q;
  logic [IdxW-1:0]        best_idx_q;
  logic [SIZE_BITS-1:0]   best_size_q;

  result_t                res_q;
  logic                   m_valid_q;
  result_t                m_res_q;

  // hole size ram
  logic [SIZE_BITS-1:0]   hole_mem [MAX_HOLES];
  logic [SIZE_BITS-1:0]   rd_data_q;

  // input fields
  logic                   in_cmd;
  logic [HoleIdxW-1:0]    in_idx;
  logic [AmountW-1:0]     in_amt;
  logic                   s_fire;
  logic                   load_ok;
  logic [IdxW-1:0]        load_addr;
  logic [SIZE_BITS-1:0]   load_size;

  logic [LimW-1:0]        limit_d;
  logic                   rd_en;
  logic [IdxW-1:0]        rd_addr;
  logic                   cand_fits;
  logic                   cand_better;
  logic [CmpW-1:0]        new_size_w;
  logic [SIZE_BITS-1:0]   new_size;

  logic                   mem_we;
  logic [IdxW-1:0]        mem_waddr;
  logic [SIZE_BITS-1:0]   mem_wdata;
  logic                   out_free;

  assign in_cmd    = s_axis_tuser_i;
  assign in_idx    = s_axis_tdata_i[HoleIdxW-1:0];
  assign in_amt    = s_axis_tdata_i[HoleIdxW +: AmountW];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;

  // loads beyond the table are answered but change nothing
  assign load_ok   = (32'(in_idx) < 32'(MAX_HOLES));
  assign load_addr = IdxW'(in_idx);
  assign load_size = SIZE_BITS'(in_amt);

  // search limit saturates at the table depth
  assign limit_d = (LimW'(hole_count_q) > LimW'(MAX_HOLES)) ? LimW'(MAX_HOLES)
                                                           : LimW'(hole_count_q);

  // one sram read per cycle while the scan pointer is below the limit
  assign rd_en   = (state_q == ST_SCAN) && (ptr_q < limit_q);
  assign rd_addr = ptr_q[IdxW-1:0];

  // compare a returned entry against the request and the best so far
  assign cand_fits   = !rd_full_q && (CmpW'(rd_data_q) >= CmpW'(amt_q));
  assign cand_better = !found_q || (rd_data_q > best_size_q);

  // found guarantees best_size_q >= amt_q, so no wrap
  assign new_size_w = CmpW'(best_size_q) - CmpW'(amt_q);
  assign new_size   = SIZE_BITS'(new_size_w);

  // single write port shared by loads and request write-back
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = load_addr;
    mem_wdata = load_size;
    if (s_fire && (in_cmd == CMD_LOAD) && load_ok) begin
      mem_we = 1'b1;
    end else if ((state_q == ST_UPDATE) && found_q) begin
      mem_we    = 1'b1;
      mem_waddr = best_idx_q;
      mem_wdata = new_size;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hole_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_data_q <= hole_mem[rd_addr];
    end
  end

  assign out_free = !m_valid_q || m_axis_tready_i;

  // control state, full marks and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hole_count_q <= CountW'(CountRst);
      full_q       <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hole_count_q <= cfg_wdata_i;
      end
      // output register drains unless a new result moves in below
      if (m_valid_q && m_axis_tready_i && (state_q != ST_OUT)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            if (in_cmd == CMD_LOAD) begin
              if (load_ok) begin
                full_q[load_addr] <= 1'b0;
                res_q.granted     <= 1'b1;
                res_q.chosen_hole <= in_idx;
                res_q.remaining   <= AmountW'(load_size);
              end else begin
                res_q <= '0;
              end
              state_q <= ST_OUT;
            end else begin
              amt_q    <= in_amt;
              limit_q  <= limit_d;
              ptr_q    <= '0;
              found_q  <= 1'b0;
              rd_vld_q <= 1'b0;
              state_q  <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          // issue side
          rd_vld_q <= rd_en;
          if (rd_en) begin
            rd_idx_q  <= rd_addr;
            rd_full_q <= full_q[rd_addr];
            ptr_q     <= ptr_q + LimW'(1);
          end
          // evaluate side, strict compare keeps the lowest index on ties
          if (rd_vld_q && cand_fits && cand_better) begin
            found_q     <= 1'b1;
            best_idx_q  <= rd_idx_q;
            best_size_q <= rd_data_q;
          end
          if (!rd_en && !rd_vld_q) begin
            state_q <= ST_UPDATE;
          end
        end

        ST_UPDATE: begin
          if (found_q) begin
            if (new_size == '0) begin
              full_q[best_idx_q] <= 1'b1;
            end
            res_q.granted     <= 1'b1;
            res_q.chosen_hole <= HoleIdxW'(best_idx_q);
            res_q.remaining   <= AmountW'(new_size);
          end else begin
            res_q <= '0;
          end
          state_q <= ST_OUT;
        end

        ST_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_res_q   <= res_q;
            state_q   <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_res_q.granted;
  assign m_axis_tdata_o  = {{(TdataW - HoleIdxW - AmountW){1'b0}},
                            m_res_q.remaining, m_res_q.chosen_hole};

  // a refused result carries an all-zero payload
  a_refused_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_res_q.granted) |-> (m_res_q.chosen_hole == '0 &&
                                         m_res_q.remaining == '0))
    else $error("refused result with nonzero payload");

  // the ram is never written while a scan reads it
  a_no_write_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q != ST_SCAN))
    else $error("hole ram write during scan");

  // the best candidate always covers the request
  a_best_fits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_UPDATE) && found_q) |-> (CmpW'(best_size_q) >= CmpW'(amt_q)))
    else $error("chosen hole smaller than request");

  // the scan pointer never passes the search limit
  a_ptr_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ptr_q <= limit_q))
    else $error("scan pointer beyond limit");

  // a load clears the full mark of its entry
  a_load_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (in_cmd == CMD_LOAD) && load_ok) |=> !full_q[$past(load_addr)])
    else $error("load left the full mark set");

endmodule : worst_fit_hole_allocator_unit

`default_nettype wire
